// ===== sv/itp_pkg.sv =====
package itp_pkg;
  localparam int MAX_BITS  = 256;
  localparam int LIMB_BITS = 64;
  localparam int MAX_OUT   = 4;
  localparam int WW        = $clog2(MAX_BITS + 1);
  localparam int NLIMB     = (MAX_BITS + LIMB_BITS - 1) / LIMB_BITS;
  localparam int LW        = $clog2(NLIMB);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_MUL   = 6'b000100,
    S_NEXT  = 6'b001000,
    S_OUT   = 6'b010000,
    S_WAIT  = 6'b100000
  } state_t;

  // what the shared multiplier is computing
  typedef enum logic [2:0] {
    OP_N1  = 3'd0,  // t = 3*inv
    OP_N2  = 3'd1,  // inv = inv*(2-t)
    OP_MUL = 3'd2,  // res = res*base
    OP_SQR = 3'd3   // base = base*base
  } op_t;
endpackage

// ===== sv/inverse_three_power_mod_pow2.sv =====
// Computes 3^(-exponent) mod 2^modulus_bits (width 0 taken as 1, capped at 256) and
// returns it as 64-bit limbs, lowest first, last one flagged. All products run on
// one bit-serial shift-and-add multiplier that takes one multiplier bit per cycle.
// The Newton steps run at widths 2, 4, .. up to w; the exponentiation then runs one
// product per bit of the exponent up to its top set bit plus one per set bit. Each
// limb is held until the sink takes it. One item is processed at a time; the input
// is ready only while idle.
module inverse_three_power_mod_pow2 (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  exponent,
  input  logic [8:0]  modulus_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] limb_value,
  output logic [1:0]  limb_index,
  output logic        last_limb
);
  localparam int MB = itp_pkg::MAX_BITS;
  localparam int LB = itp_pkg::LIMB_BITS;

  itp_pkg::state_t state;
  itp_pkg::op_t    op;
  logic [itp_pkg::WW-1:0] w, k, nk, cnt;
  logic [7:0]    e;
  logic [MB-1:0] inv, res, base, mask, acc, mcand, mplier;
  logic [itp_pkg::LW-1:0] lidx, nl_m1;
  logic [MB-1:0] sh;

  // mask of nk bits
  always_comb begin
    mask = '0;
    for (int i = 0; i < MB; i++) mask[i] = (i < int'(nk));
  end

  logic [itp_pkg::WW:0] k2;
  assign k2 = {k, 1'b0};
  assign in_ready = (state == itp_pkg::S_IDLE);
  assign sh = res >> (LB * int'(lidx));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itp_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        itp_pkg::S_IDLE: if (in_valid) begin
          e <= exponent;
          if (modulus_bits == '0) w <= itp_pkg::WW'(1);
          else if (int'(modulus_bits) > MB) w <= itp_pkg::WW'(MB);
          else w <= itp_pkg::WW'(modulus_bits);
          inv <= MB'(1);
          k <= itp_pkg::WW'(1);
          state <= itp_pkg::S_SETUP;
        end
        itp_pkg::S_SETUP: begin
          // pick the next product
          acc <= '0; cnt <= '0;
          if (k < w) begin
            nk <= (k2 < {1'b0, w}) ? k2[itp_pkg::WW-1:0] : w;
            op <= itp_pkg::OP_N1; mcand <= MB'(3); mplier <= inv;
            state <= itp_pkg::S_MUL;
          end else if (op != itp_pkg::OP_MUL && op != itp_pkg::OP_SQR) begin
            // entering exponentiation: base = inv, res = 1
            base <= inv; res <= MB'(1);
            nk <= w;
            if (e != '0) begin
              if (e[0]) begin
                op <= itp_pkg::OP_MUL; mcand <= MB'(1); mplier <= inv;
              end else begin
                op <= itp_pkg::OP_SQR; mcand <= inv; mplier <= inv;
              end
              state <= itp_pkg::S_MUL;
            end else begin
              lidx <= '0;
              nl_m1 <= itp_pkg::LW'((int'(w) - 1) / LB);
              state <= itp_pkg::S_OUT;
            end
          end else begin
            lidx <= '0;
            nl_m1 <= itp_pkg::LW'((int'(w) - 1) / LB);
            state <= itp_pkg::S_OUT;
          end
        end
        itp_pkg::S_MUL: begin
          // one multiplier bit per cycle
          if (mplier[0]) acc <= (acc + mcand) & mask;
          mplier <= mplier >> 1;
          mcand  <= (mcand << 1) & mask;
          cnt <= cnt + 1'b1;
          if (cnt == nk) state <= itp_pkg::S_NEXT;
        end
        itp_pkg::S_NEXT: begin
          acc <= '0; cnt <= '0;
          case (op)
            itp_pkg::OP_N1: begin
              op <= itp_pkg::OP_N2; mcand <= inv; mplier <= (MB'(2) - acc) & mask;
              state <= itp_pkg::S_MUL;
            end
            itp_pkg::OP_N2: begin
              inv <= acc; k <= nk; state <= itp_pkg::S_SETUP;
            end
            itp_pkg::OP_MUL: begin
              res <= acc; op <= itp_pkg::OP_SQR; mcand <= base; mplier <= base;
              state <= itp_pkg::S_MUL;
            end
            itp_pkg::OP_SQR: begin
              base <= acc; e <= e >> 1;
              if (e[7:1] == '0) state <= itp_pkg::S_SETUP;
              else begin
                state <= itp_pkg::S_MUL;
                if (e[1]) begin
                  op <= itp_pkg::OP_MUL; mcand <= res; mplier <= acc;
                end else begin
                  mcand <= acc; mplier <= acc;
                end
              end
            end
            default: state <= itp_pkg::S_SETUP;
          endcase
        end
        itp_pkg::S_OUT: begin
          limb_value <= sh[LB-1:0];
          limb_index <= 2'(lidx);
          last_limb  <= (lidx == nl_m1);
          out_valid  <= 1'b1;
          state <= itp_pkg::S_WAIT;
        end
        itp_pkg::S_WAIT: if (out_ready) begin
          out_valid <= 1'b0;
          lidx <= lidx + 1'b1;
          state <= last_limb ? itp_pkg::S_IDLE : itp_pkg::S_OUT;
        end
        default: state <= itp_pkg::S_IDLE;
      endcase
      if (state == itp_pkg::S_IDLE) op <= itp_pkg::OP_N1;
    end
  end

`ifndef SYNTHESIS
  a_ov: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == itp_pkg::S_WAIT) else $error("out_valid outside wait");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    state == itp_pkg::S_MUL |-> cnt <= nk) else $error("mul count overrun");
  a_k: assert property (@(posedge clk) disable iff (rst)
    state != itp_pkg::S_IDLE |-> k <= w) else $error("newton width past w");
`endif
endmodule
